// File: rtl/rpfs_pkg.sv
package rpfs_pkg;

    localparam int PALETTE_SLOTS_DEF = 7;
    localparam int PALETTE_SLOTS_MAX = 7;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 24;
    localparam int LEVEL_W           = 8;
    localparam int DUTY_W            = 10;

    localparam logic [2:0] COUNT_MIN   = 3'd3;
    localparam logic [2:0] COUNT_RESET = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] REG_COLOR_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_0   = 3'd1;

    localparam logic signed [3:0] POS_RESET = -4'sd1;

    localparam int DUTY_FULL  = 999;
    localparam int LEVEL_FULL = 255;
    localparam int DUTY_INT   = DUTY_FULL / LEVEL_FULL;
    localparam int DUTY_FRAC  = DUTY_FULL % LEVEL_FULL;

    localparam logic [23:0] PALETTE_RESET [PALETTE_SLOTS_MAX] = '{
        24'hFF0000, 24'hFFA500, 24'hFFFF00, 24'h00FF00,
        24'h007FFF, 24'h0000FF, 24'h8B00FF
    };

    // red in [2], green in [1], blue in [0]
    typedef logic [2:0][LEVEL_W-1:0] t_rgb;
    typedef logic [2:0][DUTY_W-1:0]  t_duty;

    typedef struct packed {
        logic signed [3:0] pos;
        logic              up;
        logic [2:0]        from_slot;
        logic [2:0]        to_slot;
    } t_plan;

    function automatic logic [2:0] clamp_count(input logic [2:0] cnt, input logic [2:0] max);
        logic [2:0] c;
        c = cnt;
        if (c < COUNT_MIN) begin
            c = COUNT_MIN;
        end else if (c > max) begin
            c = max;
        end
        return c;
    endfunction

    // bounce rules for the start of a segment
    function automatic t_plan seg_plan(input logic signed [3:0] pos, input logic up,
                                       input logic [2:0] cnt);
        t_plan             p;
        logic signed [4:0] c;
        logic signed [4:0] q;
        logic signed [4:0] t_pos;
        logic signed [4:0] t_from;
        logic signed [4:0] t_to;
        logic              t_up;
        c    = $signed({2'b00, cnt});
        t_up = up;
        if (up) begin
            q      = 5'(pos) + 5'sd1;
            t_pos  = q;
            t_from = q;
            if (q >= c) begin
                t_up   = 1'b0;
                t_pos  = c - 5'sd2;
                t_from = c - 5'sd2;
                t_to   = c - 5'sd3;
            end else if (q == c - 5'sd1) begin
                t_to = c - 5'sd2;
            end else begin
                t_to = q + 5'sd1;
            end
        end else begin
            q      = 5'(pos) - 5'sd1;
            t_pos  = q;
            t_from = q;
            if (q <= -5'sd1) begin
                t_up   = 1'b1;
                t_pos  = 5'sd1;
                t_from = 5'sd1;
                t_to   = 5'sd2;
            end else if (q == 5'sd0) begin
                t_to = 5'sd1;
            end else begin
                t_to = q - 5'sd1;
            end
        end
        p.pos       = t_pos[3:0];
        p.up        = t_up;
        p.from_slot = t_from[2:0];
        p.to_slot   = t_to[2:0];
        return p;
    endfunction

    // floor(level*999/255) as 3*level + floor(234*level/255)
    function automatic logic [DUTY_W-1:0] duty_of(input logic [LEVEL_W-1:0] level);
        logic [15:0] y;
        logic [16:0] sum;
        logic [8:0]  est;
        logic [15:0] rem;
        logic [9:0]  q;
        y   = 16'(level) * 16'(DUTY_FRAC);
        sum = {1'b0, y} + 17'(y[15:8]);
        est = sum[16:8];
        rem = y - 16'(est) * 16'(LEVEL_FULL);
        q   = 10'(est) + ((rem >= 16'(LEVEL_FULL)) ? 10'd1 : 10'd0);
        return 10'(level) * 10'(DUTY_INT) + q;
    endfunction

endpackage

// File: rtl/rgb_palette_fade_sequencer.sv
// channel  | direction | handshake           | payload
// ---------+-----------+---------------------+-------------------------------------------
// tick in  | in        | i_valid / o_ready   | i_advance
// result   | out       | o_valid / i_ready   | o_duty_red/green/blue, o_segment_done,
//          |           |                     | o_source_color, o_target_color
// config   | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// one item per cycle while o_ready is high; its result is registered and shown the cycle after acceptance
// the fade state registers are the result register, so a waiting result does not
// block the next item when the output is being taken in the same cycle
// palette colours for the next tick are prefetched into two read registers
// synchronous active-low reset, no clearing pass; o_ready drops only while a
// result waits and i_ready is low
module rgb_palette_fade_sequencer #(
    parameter int PALETTE_SLOTS = rpfs_pkg::PALETTE_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_advance,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [rpfs_pkg::DUTY_W-1:0]        o_duty_red,
    output logic [rpfs_pkg::DUTY_W-1:0]        o_duty_green,
    output logic [rpfs_pkg::DUTY_W-1:0]        o_duty_blue,
    output logic                               o_segment_done,
    output logic [2:0]                         o_source_color,
    output logic [2:0]                         o_target_color,
    input  logic                               i_cfg_we,
    input  logic [rpfs_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [rpfs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int         SLOT_W    = $clog2(PALETTE_SLOTS);
    localparam logic [2:0] SLOTS_TOP = 3'(PALETTE_SLOTS);

    logic [23:0]            r_palette [PALETTE_SLOTS];
    logic [2:0]             r_count;
    logic signed [3:0]      r_pos;
    logic                   r_up;
    logic                   r_finished;
    logic [2:0]             r_from_slot;
    logic [2:0]             r_to_slot;
    rpfs_pkg::t_rgb         r_level;
    rpfs_pkg::t_duty        r_duty;
    logic                   r_out_valid;
    logic [23:0]            r_rd_from;
    logic [23:0]            r_rd_to;

    logic [2:0]             n_count;
    logic signed [3:0]      n_pos;
    logic                   n_up;
    logic                   n_finished;
    logic [2:0]             n_from_slot;
    logic [2:0]             n_to_slot;
    rpfs_pkg::t_rgb         n_level;
    rpfs_pkg::t_duty        n_duty;

    logic                   accept;
    logic                   tick;
    logic                   cnt_wr;
    logic                   pal_wr;
    logic [2:0]             wr_slot;
    rpfs_pkg::t_plan        plan_cur;
    rpfs_pkg::t_plan        plan_nxt;
    rpfs_pkg::t_rgb         base;
    rpfs_pkg::t_rgb         goal;
    logic [2:0]             match;
    logic [2:0]             rd_from_addr;
    logic [2:0]             rd_to_addr;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign tick    = accept && i_advance;

    assign cnt_wr  = i_cfg_we && (i_cfg_index == rpfs_pkg::REG_COLOR_COUNT);
    assign wr_slot = i_cfg_index - rpfs_pkg::REG_PALETTE_0;
    assign pal_wr  = i_cfg_we && (i_cfg_index != rpfs_pkg::REG_COLOR_COUNT)
                     && (wr_slot < SLOTS_TOP);
    assign n_count = cnt_wr ? i_cfg_data[2:0] : r_count;

    assign plan_cur = rpfs_pkg::seg_plan(r_pos, r_up,
                                         rpfs_pkg::clamp_count(r_count, SLOTS_TOP));

    always_comb begin
        n_pos       = r_pos;
        n_up        = r_up;
        n_finished  = r_finished;
        n_from_slot = r_from_slot;
        n_to_slot   = r_to_slot;
        n_level     = r_level;
        n_duty      = r_duty;
        base        = r_finished ? rpfs_pkg::t_rgb'(r_rd_from) : r_level;
        goal        = rpfs_pkg::t_rgb'(r_rd_to);
        match       = '0;
        for (int ch = 0; ch < 3; ch++) begin
            if (base[ch] == goal[ch]) begin
                match[ch] = 1'b1;
            end
        end
        if (tick) begin
            if (r_finished) begin
                n_pos       = plan_cur.pos;
                n_up        = plan_cur.up;
                n_from_slot = plan_cur.from_slot;
                n_to_slot   = plan_cur.to_slot;
            end
            for (int ch = 0; ch < 3; ch++) begin
                n_level[ch] = base[ch];
                if (base[ch] != goal[ch]) begin
                    n_level[ch] = (base[ch] < goal[ch]) ? base[ch] + 8'd1 : base[ch] - 8'd1;
                    n_duty[ch]  = rpfs_pkg::duty_of(n_level[ch]);
                    match[ch]   = (n_level[ch] == goal[ch]);
                end
            end
            n_finished = &match;
        end
    end

    // colours needed by the tick after this edge
    assign plan_nxt     = rpfs_pkg::seg_plan(n_pos, n_up,
                                             rpfs_pkg::clamp_count(n_count, SLOTS_TOP));
    assign rd_from_addr = plan_nxt.from_slot;
    assign rd_to_addr   = n_finished ? plan_nxt.to_slot : n_to_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PALETTE_SLOTS; i++) begin
                r_palette[i] <= rpfs_pkg::PALETTE_RESET[i];
            end
        end else if (pal_wr) begin
            r_palette[wr_slot[SLOT_W-1:0]] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_from <= rpfs_pkg::PALETTE_RESET[0];
            r_rd_to   <= rpfs_pkg::PALETTE_RESET[1];
        end else begin
            if (pal_wr && (wr_slot == rd_from_addr)) begin
                r_rd_from <= i_cfg_data;
            end else begin
                r_rd_from <= r_palette[rd_from_addr[SLOT_W-1:0]];
            end
            if (pal_wr && (wr_slot == rd_to_addr)) begin
                r_rd_to <= i_cfg_data;
            end else begin
                r_rd_to <= r_palette[rd_to_addr[SLOT_W-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= rpfs_pkg::COUNT_RESET;
            r_pos       <= rpfs_pkg::POS_RESET;
            r_up        <= 1'b1;
            r_finished  <= 1'b1;
            r_from_slot <= '0;
            r_to_slot   <= '0;
            r_level     <= '0;
            r_duty      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_up        <= n_up;
            r_finished  <= n_finished;
            r_from_slot <= n_from_slot;
            r_to_slot   <= n_to_slot;
            r_level     <= n_level;
            r_duty      <= n_duty;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_duty_red     = r_duty[2];
    assign o_duty_green   = r_duty[1];
    assign o_duty_blue    = r_duty[0];
    assign o_segment_done = r_finished;
    assign o_source_color = r_from_slot;
    assign o_target_color = r_to_slot;

endmodule

// File: tb/rgb_palette_fade_sequencer_tb.sv
module rgb_palette_fade_sequencer_tb;

    localparam int IDLE_LIMIT  = 2000;
    localparam int TICK_TARGET = 1300;
    localparam int DUTY_W      = rpfs_pkg::DUTY_W;
    localparam int LEVEL_W     = rpfs_pkg::LEVEL_W;

    typedef struct packed {
        logic [DUTY_W-1:0] red;
        logic [DUTY_W-1:0] green;
        logic [DUTY_W-1:0] blue;
        logic              done;
        logic [2:0]        src;
        logic [2:0]        dst;
    } t_fade_result;

    class t_fade_scoreboard;
        logic [2:0]          count_word;
        logic [23:0]         colors [8];
        int                  position;
        bit                  going_up;
        bit                  finished;
        logic [2:0]          from_slot;
        logic [2:0]          to_slot;
        logic [LEVEL_W-1:0]  level [3];
        logic [DUTY_W-1:0]   duty [3];
        t_fade_result        due_results [$];
        int                  mismatches;

        function new();
            count_word = rpfs_pkg::COUNT_RESET;
            for (int k = 0; k < rpfs_pkg::PALETTE_SLOTS_MAX; k++) begin
                colors[k] = rpfs_pkg::PALETTE_RESET[k];
            end
            colors[7]  = '0;
            position   = -1;
            going_up   = 1'b1;
            finished   = 1'b1;
            from_slot  = '0;
            to_slot    = '0;
            mismatches = 0;
            for (int ch = 0; ch < 3; ch++) begin
                level[ch] = '0;
                duty[ch]  = '0;
            end
        endfunction

        function void write_reg(logic [rpfs_pkg::CFG_INDEX_W-1:0] idx,
                                logic [rpfs_pkg::CFG_DATA_W-1:0] val);
            if (idx == rpfs_pkg::REG_COLOR_COUNT) begin
                count_word = val[2:0];
            end else begin
                colors[idx - rpfs_pkg::REG_PALETTE_0] = val;
            end
        endfunction

        // channel 0 red, 1 green, 2 blue
        function logic [LEVEL_W-1:0] channel(logic [2:0] slot, int ch);
            return LEVEL_W'(colors[slot] >> (16 - 8 * ch));
        endfunction

        function void bounce();
            int span;
            int src_pos;
            int dst_pos;
            span = count_word;
            if (span < rpfs_pkg::COUNT_MIN) span = rpfs_pkg::COUNT_MIN;
            if (span > rpfs_pkg::PALETTE_SLOTS_DEF) span = rpfs_pkg::PALETTE_SLOTS_DEF;
            if (going_up) begin
                position++;
                if (position >= span) begin
                    going_up = 1'b0;
                    position = span - 2;
                    src_pos  = position;
                    dst_pos  = position - 1;
                end else if (position == span - 1) begin
                    src_pos = position;
                    dst_pos = span - 2;
                end else begin
                    src_pos = position;
                    dst_pos = position + 1;
                end
            end else begin
                position--;
                if (position <= -1) begin
                    going_up = 1'b1;
                    position = 1;
                    src_pos  = 1;
                    dst_pos  = 2;
                end else if (position == 0) begin
                    src_pos = 0;
                    dst_pos = 1;
                end else begin
                    src_pos = position;
                    dst_pos = position - 1;
                end
            end
            from_slot = 3'(src_pos);
            to_slot   = 3'(dst_pos);
            for (int ch = 0; ch < 3; ch++) begin
                level[ch] = channel(from_slot, ch);
            end
        endfunction

        function void take_tick(logic advance);
            t_fade_result      r;
            logic [LEVEL_W-1:0] goal;
            bit                all_match;
            if (advance) begin
                if (finished) begin
                    finished = 1'b0;
                    bounce();
                end
                all_match = 1'b1;
                for (int ch = 0; ch < 3; ch++) begin
                    goal = channel(to_slot, ch);
                    if (level[ch] != goal) begin
                        if (level[ch] < goal) level[ch]++;
                        else level[ch]--;
                        duty[ch] = DUTY_W'((int'(level[ch]) * rpfs_pkg::DUTY_FULL)
                                           / rpfs_pkg::LEVEL_FULL);
                    end
                    if (level[ch] != goal) all_match = 1'b0;
                end
                if (all_match) finished = 1'b1;
            end
            r.red   = duty[0];
            r.green = duty[1];
            r.blue  = duty[2];
            r.done  = finished;
            r.src   = from_slot;
            r.dst   = to_slot;
            due_results.push_back(r);
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void compare_output(t_fade_result got);
            t_fade_result want;
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: duty %0d/%0d/%0d done %0d slots %0d->%0d",
                             got.red, got.green, got.blue, got.done, got.src, got.dst);
                end
                return;
            end
            want = due_results.pop_front();
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.done !== want.done || got.src !== want.src || got.dst !== want.dst) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"exp duty %0d/%0d/%0d done %0d slots %0d->%0d, ",
                              "act duty %0d/%0d/%0d done %0d slots %0d->%0d"},
                             want.red, want.green, want.blue, want.done, want.src, want.dst,
                             got.red, got.green, got.blue, got.done, got.src, got.dst);
                end
            end
        endfunction
    endclass

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    logic                            o_ready;
    logic                            i_advance   = 1'b0;
    logic                            o_valid;
    logic                            i_ready     = 1'b0;
    logic [DUTY_W-1:0]               o_duty_red;
    logic [DUTY_W-1:0]               o_duty_green;
    logic [DUTY_W-1:0]               o_duty_blue;
    logic                            o_segment_done;
    logic [2:0]                      o_source_color;
    logic [2:0]                      o_target_color;
    logic                            i_cfg_we    = 1'b0;
    logic [rpfs_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [rpfs_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;

    t_fade_scoreboard sb = new();
    logic [23:0]    plan_colors [7];
    int             ticks_sent  = 0;
    int             hold_cycles = 0;
    bit             steady      = 1'b0;
    int             stall_count = 0;

    rgb_palette_fade_sequencer uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_advance      (i_advance),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_duty_red     (o_duty_red),
        .o_duty_green   (o_duty_green),
        .o_duty_blue    (o_duty_blue),
        .o_segment_done (o_segment_done),
        .o_source_color (o_source_color),
        .o_target_color (o_target_color),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                sb.compare_output('{o_duty_red, o_duty_green, o_duty_blue,
                                    o_segment_done, o_source_color, o_target_color});
            end
            if (i_valid && o_ready) begin
                sb.take_tick(i_advance);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= IDLE_LIMIT) begin
                $display("rgb_palette_fade_sequencer: mismatch");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin
        int n;
        int r;
        forever begin
            if (hold_cycles > 0) begin
                n           = hold_cycles;
                hold_cycles = 0;
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (steady) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 19);
                if (r < 12) begin
                    i_ready <= 1'b1;
                    n = $urandom_range(1, 8);
                end else if (r < 18) begin
                    i_ready <= 1'b0;
                    n = $urandom_range(1, 3);
                end else begin
                    i_ready <= 1'b0;
                    n = $urandom_range(10, 30);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    task automatic offer_tick(input logic advance);
        int gap;
        int r;
        i_valid   <= 1'b1;
        i_advance <= advance;
        do @(posedge i_clk); while (!o_ready);
        ticks_sent++;
        gap = 0;
        if (!steady) begin
            r = $urandom_range(0, 19);
            if (r >= 18) gap = $urandom_range(8, 25);
            else if (r >= 12) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic cfg_write(input logic [rpfs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rpfs_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    task automatic apply_setup(input logic [rpfs_pkg::CFG_DATA_W-1:0] count_val,
                               input bit with_count);
        if (with_count) cfg_write(rpfs_pkg::REG_COLOR_COUNT, count_val);
        for (int k = 0; k < rpfs_pkg::PALETTE_SLOTS_MAX; k++) begin
            cfg_write(rpfs_pkg::REG_PALETTE_0 + 3'(k), plan_colors[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int          phase;
        int          style;
        int          v;
        int          n;
        logic [23:0] base;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset palette, idle ticks before the first segment
        offer_tick(1'b0);
        offer_tick(1'b0);
        offer_tick(1'b1);
        offer_tick(1'b1);
        offer_tick(1'b1);
        offer_tick(1'b0);
        offer_tick(1'b1);
        drain();

        // one-step segments hitting full and zero duty
        plan_colors = '{24'hFF0001, 24'hFE0000, 24'hFF0000, 24'h000000,
                        24'hFFFFFF, 24'h7F7F7F, 24'h808080};
        apply_setup({21'($urandom), rpfs_pkg::COUNT_MIN}, 1'b1);
        for (int k = 0; k < 10; k++) begin
            offer_tick(k != 4);
        end
        drain();

        // count below minimum, all colours equal
        plan_colors = '{default: 24'h5A5A5A};
        apply_setup({21'($urandom), 3'd1}, 1'b1);
        repeat (6) offer_tick(1'b1);
        drain();

        phase = 0;
        while (ticks_sent < TICK_TARGET) begin
            phase++;
            style = $urandom_range(0, 9);
            base  = 24'($urandom);
            for (int k = 0; k < rpfs_pkg::PALETTE_SLOTS_MAX; k++) begin
                if (k > 0 && $urandom_range(0, 5) == 0) begin
                    plan_colors[k] = plan_colors[k-1];
                end else begin
                    for (int ch = 0; ch < 3; ch++) begin
                        if (style < 7) begin
                            v = int'(base[8*ch +: 8]) + int'($urandom_range(0, 6)) - 3;
                            if (v < 0) v = 0;
                            if (v > 255) v = 255;
                        end else if (style < 9) begin
                            v = $urandom_range(0, 1) ? 255 - int'($urandom_range(0, 1))
                                                     : int'($urandom_range(0, 1));
                        end else begin
                            v = $urandom_range(0, 255);
                        end
                        plan_colors[k][8*ch +: 8] = 8'(v);
                    end
                end
            end
            apply_setup({21'($urandom), 3'($urandom_range(0, 7))}, $urandom_range(0, 3) != 0);
            steady = (phase % 4 == 3);
            if (phase == 2) hold_cycles = 80;
            n = $urandom_range(40, 120);
            repeat (n) offer_tick($urandom_range(0, 6) != 0);
            drain();
        end

        steady = 1'b0;
        repeat (4) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("rgb_palette_fade_sequencer: match");
        end else begin
            $display("rgb_palette_fade_sequencer: mismatch");
        end
        $finish;
    end

endmodule
